/* rtl/rsp_pkg.sv */
package rsp_pkg;

    // Character codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Field widths
    localparam int LEN_W  = 16;
    localparam int VAL_W  = 64;
    localparam int DIG_W  = 4;
    localparam int PROD_W = VAL_W + 4;

    // Length counter saturates at min(MAX_NAME_LEN, 65535)
    localparam longint unsigned MAX_NAME_LEN = 65535;
    localparam longint unsigned LEN_CAP      = (MAX_NAME_LEN < 65535) ? MAX_NAME_LEN : 65535;
    localparam logic [LEN_W-1:0] LEN_CAP_W   = LEN_W'(LEN_CAP);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        K_COLON,
        K_DASH,
        K_DIGIT,
        K_OTHER
    } t_kind;

    typedef enum logic [2:0] {
        ST_PLAIN     = 3'd0,
        ST_VALID     = 3'd1,
        ST_EMPTY_NS  = 3'd2,
        ST_START_OVF = 3'd3,
        ST_END_OVF   = 3'd4,
        ST_ORDER     = 3'd5
    } t_status;

    // Classified input word
    typedef struct packed {
        t_kind             kind;
        logic [DIG_W-1:0]  digit;
        logic              last;
    } t_word;

    // Suffix state captured at the last byte of a name
    typedef struct packed {
        logic [LEN_W-1:0] name_len;
        logic [LEN_W-1:0] colon_pos;
        logic             plain;
        logic             start_ovf;
        logic             end_ovf;
        logic [VAL_W-1:0] start_acc;
        logic [VAL_W-1:0] end_acc;
    } t_snap;

endpackage

/* rtl/rsp_if.sv */
interface rsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink   (input valid, input ch, input last_char, output ready);
endinterface

interface rsp_out_if;
    logic        valid;
    logic        ready;
    logic        has_coords;
    logic [15:0] name_length;
    logic [63:0] start_value;
    logic [63:0] end_value;
    logic [2:0]  status;

    modport source (output valid, output has_coords, output name_length,
                    output start_value, output end_value, output status, input ready);
    modport sink   (input valid, input has_coords, input name_length,
                    input start_value, input end_value, input status, output ready);
endinterface

/* rtl/rsp_front.sv */
module rsp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rsp_in_if.sink        i_in,
    output logic          o_valid,
    output rsp_pkg::t_word o_word,
    input  logic          i_ready
);
    import rsp_pkg::*;

    logic       r_valid;
    t_word      r_word;
    t_word      n_word;
    logic [7:0] w_off;

    // Pipeline register: take a new byte when it is empty or the held word can move on
    assign i_in.ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    // Byte classification
    always_comb begin
        w_off        = i_in.ch - CH_ZERO;
        n_word.digit = w_off[DIG_W-1:0];
        n_word.last  = i_in.last_char;
        if (i_in.ch == CH_COLON) begin
            n_word.kind = K_COLON;
        end else if (i_in.ch == CH_DASH) begin
            n_word.kind = K_DASH;
        end else if (i_in.ch >= CH_ZERO && i_in.ch <= CH_NINE) begin
            n_word.kind = K_DIGIT;
        end else begin
            n_word.kind = K_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_word <= n_word;
        end
    end

endmodule

/* rtl/rsp_queue.sv */
module rsp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rsp_pkg::t_word i_word,
    output logic           o_ready,
    output logic           o_valid,
    output rsp_pkg::t_word o_word,
    input  logic           i_ready
);
    import rsp_pkg::*;

    t_word             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Fill level
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

/* rtl/rsp_back.sv */
module rsp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rsp_pkg::t_word i_word,
    output logic           o_ready,
    output logic           o_valid,
    output rsp_pkg::t_snap o_snap,
    input  logic           i_ready
);
    import rsp_pkg::*;

    // Per-name parse state
    typedef struct packed {
        logic [LEN_W-1:0] pos;
        logic [LEN_W-1:0] colon_pos;
        logic             colon_seen;
        logic             dash_seen;
        logic [VAL_W-1:0] start_acc;
        logic [VAL_W-1:0] end_acc;
        logic             start_ovf;
        logic             end_ovf;
        logic             start_ne;
        logic             end_ne;
        logic             bad;
    } t_state;

    t_state             r_st;
    t_state             n_st;
    logic               r_snap_valid;
    t_snap              r_snap;
    t_snap              n_snap;
    logic               w_take;
    logic [VAL_W-1:0]   w_acc;
    logic [PROD_W-1:0]  w_prod;
    logic               w_fits;

    assign o_ready = !r_snap_valid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_snap_valid;
    assign o_snap  = r_snap;

    // Shared multiply-by-ten and add for whichever run is active
    always_comb begin
        w_acc  = r_st.dash_seen ? r_st.end_acc : r_st.start_acc;
        w_prod = ({{(PROD_W-VAL_W){1'b0}}, w_acc} << 3)
               + ({{(PROD_W-VAL_W){1'b0}}, w_acc} << 1)
               + PROD_W'(i_word.digit);
        w_fits = (w_prod[PROD_W-1:VAL_W] == '0);
    end

    // State update for one byte
    always_comb begin
        n_st = r_st;
        unique case (i_word.kind)
            K_COLON: begin
                n_st.colon_seen = 1'b1;
                n_st.colon_pos  = r_st.pos;
                n_st.dash_seen  = 1'b0;
                n_st.start_acc  = '0;
                n_st.end_acc    = '0;
                n_st.start_ovf  = 1'b0;
                n_st.end_ovf    = 1'b0;
                n_st.start_ne   = 1'b0;
                n_st.end_ne     = 1'b0;
                n_st.bad        = 1'b0;
            end
            K_DASH: begin
                if (r_st.colon_seen) begin
                    if (r_st.dash_seen) begin
                        n_st.bad = 1'b1;
                    end else begin
                        n_st.dash_seen = 1'b1;
                    end
                end
            end
            K_DIGIT: begin
                if (r_st.colon_seen) begin
                    if (r_st.dash_seen) begin
                        n_st.end_ne = 1'b1;
                        if (!r_st.end_ovf) begin
                            if (w_fits) begin
                                n_st.end_acc = w_prod[VAL_W-1:0];
                            end else begin
                                n_st.end_ovf = 1'b1;
                            end
                        end
                    end else begin
                        n_st.start_ne = 1'b1;
                        if (!r_st.start_ovf) begin
                            if (w_fits) begin
                                n_st.start_acc = w_prod[VAL_W-1:0];
                            end else begin
                                n_st.start_ovf = 1'b1;
                            end
                        end
                    end
                end
            end
            K_OTHER: begin
                if (r_st.colon_seen) begin
                    n_st.bad = 1'b1;
                end
            end
            default: begin
                n_st = r_st;
            end
        endcase
        // Saturating length counter
        if (r_st.pos < LEN_CAP_W) begin
            n_st.pos = r_st.pos + 1'b1;
        end
    end

    // Snapshot taken at the last byte
    always_comb begin
        n_snap.name_len  = n_st.pos;
        n_snap.colon_pos = n_st.colon_pos;
        n_snap.plain     = !n_st.colon_seen || !n_st.dash_seen || n_st.bad
                           || !n_st.start_ne || !n_st.end_ne;
        n_snap.start_ovf = n_st.start_ovf;
        n_snap.end_ovf   = n_st.end_ovf;
        n_snap.start_acc = n_st.start_acc;
        n_snap.end_acc   = n_st.end_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_take) begin
            r_st <= i_word.last ? '0 : n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (o_ready) begin
            r_snap_valid <= w_take && i_word.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_word.last) begin
            r_snap <= n_snap;
        end
    end

endmodule

/* rtl/rsp_result.sv */
module rsp_result (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rsp_pkg::t_snap i_snap,
    output logic           o_ready,
    rsp_out_if.source      o_out
);
    import rsp_pkg::*;

    logic              r_out_valid;
    logic              r_has;
    logic [LEN_W-1:0]  r_len;
    logic [VAL_W-1:0]  r_start;
    logic [VAL_W-1:0]  r_end;
    t_status           r_status;
    t_status           n_status;
    logic              w_ok;
    logic              w_take;

    assign o_ready           = !r_out_valid || o_out.ready;
    assign w_take            = i_valid && o_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.has_coords  = r_has;
    assign o_out.name_length = r_len;
    assign o_out.start_value = r_start;
    assign o_out.end_value   = r_end;
    assign o_out.status      = r_status;

    // Status in priority order
    always_comb begin
        if (i_snap.plain) begin
            n_status = ST_PLAIN;
        end else if (i_snap.colon_pos == '0) begin
            n_status = ST_EMPTY_NS;
        end else if (i_snap.start_ovf) begin
            n_status = ST_START_OVF;
        end else if (i_snap.end_ovf) begin
            n_status = ST_END_OVF;
        end else if (i_snap.end_acc <= i_snap.start_acc) begin
            n_status = ST_ORDER;
        end else begin
            n_status = ST_VALID;
        end
        w_ok = (n_status == ST_VALID);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_has    <= w_ok;
            r_len    <= w_ok ? i_snap.colon_pos : i_snap.name_len;
            r_start  <= w_ok ? i_snap.start_acc : '0;
            r_end    <= w_ok ? i_snap.end_acc : '0;
            r_status <= n_status;
        end
    end

endmodule

/* rtl/region_suffix_parser_unit.sv */
// Throughput: one byte per cycle while o_out.ready accepts results, with no gap between names.
// The result word is offered after its last byte is accepted, by way of the
// front register, front/back queue, back snapshot register and result register.
// Reset: i_rst_n is synchronous, active low; it empties the queue and the
// output stage and clears all per-name parse state. No clearing pass.
module region_suffix_parser_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsp_in_if.sink    i_in,
    rsp_out_if.source o_out
);
    import rsp_pkg::*;

    logic  w_fr_valid;
    logic  w_fr_ready;
    t_word w_fr_word;
    logic  w_q_valid;
    logic  w_q_ready;
    t_word w_q_word;
    logic  w_snap_valid;
    logic  w_snap_ready;
    t_snap w_snap;

    // Front: accept and classify bytes
    rsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_fr_valid),
        .o_word  (w_fr_word),
        .i_ready (w_fr_ready)
    );

    // Decoupling queue
    rsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .i_word  (w_fr_word),
        .o_ready (w_fr_ready),
        .o_valid (w_q_valid),
        .o_word  (w_q_word),
        .i_ready (w_q_ready)
    );

    // Back: suffix tracking and digit accumulation
    rsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_word  (w_q_word),
        .o_ready (w_q_ready),
        .o_valid (w_snap_valid),
        .o_snap  (w_snap),
        .i_ready (w_snap_ready)
    );

    // Status decision and output register
    rsp_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_snap_valid),
        .i_snap  (w_snap),
        .o_ready (w_snap_ready),
        .o_out   (o_out)
    );

    // Coordinates are reported only together with a valid status
    a_coords_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.has_coords == (o_out.status == ST_VALID)))
        else $error("has_coords disagrees with status");

    // Anything but a valid result carries zero coordinates
    a_zero_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.has_coords) |->
            (o_out.start_value == '0 && o_out.end_value == '0))
        else $error("nonzero coordinates on a result without coordinates");

    // A valid range is strictly increasing
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.has_coords) |-> (o_out.end_value > o_out.start_value))
        else $error("valid result with end not above start");

    // No result word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result word present after reset");

endmodule
